// ----- rtl/spcp_pkg.sv -----
// Shared constants for the segment pair closest points unit.
package spcp_pkg;

    localparam int THR_W = 32;
    localparam logic [THR_W-1:0] THR_RESET = 32'd1;
    localparam int AXES = 3;
    localparam int IN_FIELDS = 12;
    localparam int OUT_FIELDS = 6;

endpackage

// ----- rtl/spcp_dly.sv -----
// Delay line of registers that advances with the pipeline enable.
module spcp_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [N-1:0][W-1:0] r_sr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[N-1];

endmodule

// ----- rtl/spcp_mul.sv -----
// Two-stage signed multiplier built from four registered partial products.
module spcp_mul #(
    parameter int AW = 34,
    parameter int BW = 34
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);

    localparam int PW = AW + BW;
    localparam int HA = AW / 2;
    localparam int HB = BW / 2;

    logic signed [PW-1:0] w_a_lo, w_a_hi, w_b_lo, w_b_hi;
    logic signed [PW-1:0] r_ll, r_lh, r_hl, r_hh, r_p;

    // Low halves are unsigned, high halves carry the sign.
    assign w_a_lo = $signed(PW'(i_a[HA-1:0]));
    assign w_a_hi = PW'($signed(i_a[AW-1:HA]));
    assign w_b_lo = $signed(PW'(i_b[HB-1:0]));
    assign w_b_hi = PW'($signed(i_b[BW-1:HB]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= w_a_lo * w_b_lo;
            r_lh <= w_a_lo * w_b_hi;
            r_hl <= w_a_hi * w_b_lo;
            r_hh <= w_a_hi * w_b_hi;
            r_p  <= r_ll + (r_lh <<< HB) + (r_hl <<< HA) + (r_hh <<< (HA + HB));
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/spcp_div.sv -----
// Pipelined restoring divider giving clamp(num/den, 0, 1) as a Q1.QB fraction.
module spcp_div #(
    parameter int NW = 40,
    parameter int DW = 40,
    parameter int QB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    input  logic                 i_zero,
    output logic [QB:0]          o_q
);

    localparam int MW = ((NW > DW) ? NW : DW) + 1;
    localparam int RW = DW + 1;

    logic signed [MW-1:0] w_num, w_den;
    logic [QB:0]          r_done;
    logic [QB:0][QB:0]    r_q;
    logic [QB:0][RW-1:0]  r_rem;
    logic [QB:0][DW-1:0]  r_den;

    assign w_num = MW'(i_num);
    assign w_den = MW'(i_den);

    // Entry stage settles the clamped cases; the quotient steps skip them.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_rem[0] <= w_num[RW-1:0];
            if (i_zero || w_num <= 0) begin
                r_done[0] <= 1'b1;
                r_q[0]    <= '0;
            end else if (w_num >= w_den) begin
                r_done[0] <= 1'b1;
                r_q[0]    <= {1'b1, {QB{1'b0}}};
            end else begin
                r_done[0] <= 1'b0;
                r_q[0]    <= '0;
            end
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        logic [RW-1:0] w_sh, w_dx;
        assign w_sh = {r_rem[j-1][RW-2:0], 1'b0};
        assign w_dx = {1'b0, r_den[j-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j]  <= r_den[j-1];
                r_done[j] <= r_done[j-1];
                if (r_done[j-1]) begin
                    r_q[j]   <= r_q[j-1];
                    r_rem[j] <= r_rem[j-1];
                end else if (w_sh >= w_dx) begin
                    r_q[j]   <= {r_q[j-1][QB-1:0], 1'b1};
                    r_rem[j] <= w_sh - w_dx;
                end else begin
                    r_q[j]   <= {r_q[j-1][QB-1:0], 1'b0};
                    r_rem[j] <= w_sh;
                end
            end
        end
    end

    assign o_q = r_q[QB];

endmodule

// ----- rtl/spcp_point.sv -----
// Two-stage point generator: start + direction * fraction, rounded and saturated.
module spcp_point #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_p,
    input  logic signed [CW:0]   i_d,
    input  logic [FB:0]          i_s,
    output logic signed [CW-1:0] o_q
);

    localparam int PRW = CW + FB + 3;
    localparam int VW  = PRW + 1;

    logic signed [PRW-1:0] r_prod, w_half, w_rnd;
    logic signed [CW-1:0]  r_p, r_q;
    logic signed [VW-1:0]  w_v, w_max, w_min;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PRW'(i_d) * $signed(PRW'(i_s));
            r_p    <= i_p;
        end
    end

    // Ties round towards plus infinity.
    assign w_half = $signed(PRW'(1)) <<< (FB - 1);
    assign w_rnd  = (r_prod + w_half) >>> FB;
    assign w_v    = VW'(r_p) + VW'(w_rnd);
    assign w_max  = VW'({1'b0, {(CW-1){1'b1}}});
    assign w_min  = ~w_max;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_v > w_max) begin
                r_q <= w_max[CW-1:0];
            end else if (w_v < w_min) begin
                r_q <= w_min[CW-1:0];
            end else begin
                r_q <= w_v[CW-1:0];
            end
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/segment_pair_closest_points_unit.sv -----
// Top level of the segment pair closest points unit.
// Takes one pair of 3D segments per clock and returns the closest point on each. Each result word
// reaches the master side through two chained quotient pipelines, one for the segment one
// parameter and one for the segment two parameter, each FRAC_BITS+1 stages long.
// Throughput is one word per cycle; the whole pipeline holds only while a finished word waits
// and the last stage is full. The threshold register may be written only while the unit is idle.
module segment_pair_closest_points_unit
    import spcp_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // seg1_start_x, seg1_start_y, seg1_start_z, seg1_end_x, seg1_end_y, seg1_end_z,
    // seg2_start_x, seg2_start_y, seg2_start_z, seg2_end_x, seg2_end_y, seg2_end_z
    input  logic [((IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // near1_x, near1_y, near1_z, near2_x, near2_y, near2_z
    output logic [((OUT_FIELDS*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [THR_W-1:0]      i_cfg_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int DIFW  = CW + 1;
    localparam int PW    = 2 * DIFW + 2;
    localparam int DETW  = 2 * PW + 1;
    localparam int NTW   = PW + FB + 3;
    localparam int D4W   = PW + FB + 1;
    localparam int LD    = FB + 1;
    localparam int NST   = 16 + 2 * LD;
    localparam int SEL   = 13 + 2 * LD;
    localparam int OUT_W = ((OUT_FIELDS * CW + 7) / 8) * 8;
    localparam int SLW   = CW + DIFW;
    localparam int GEOW  = 2 * AXES * SLW;
    localparam int LW    = ((PW > THR_W + FB) ? PW : THR_W + FB) + 1;
    localparam int TW    = ((DETW > THR_W + 3 * FB) ? DETW : THR_W + 3 * FB) + 1;

    logic               w_en;
    logic [NST-1:0]     r_vld;
    logic [THR_W-1:0]   r_thr;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data, n_out_data;

    // Threshold register.
    assign o_cfg_ready = i_rst_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // The pipeline holds only when its last stage is full and the output word is not taken.
    assign w_en          = !(r_vld[NST-1] && r_out_valid && !m_axis_tready);
    assign s_axis_tready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // Input register and differences.
    logic signed [CW-1:0]   r_c [IN_FIELDS];
    logic signed [CW-1:0]   r_p [2*AXES];
    logic signed [DIFW-1:0] r_d [2*AXES];
    logic signed [DIFW-1:0] r_r [AXES];

    for (genvar k = 0; k < IN_FIELDS; k++) begin : g_in
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c[k] <= s_axis_tdata[k*CW +: CW];
            end
        end
    end

    for (genvar j = 0; j < AXES; j++) begin : g_diff
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_p[j]        <= r_c[j];
                r_p[AXES+j]   <= r_c[2*AXES+j];
                r_d[j]        <= DIFW'(r_c[AXES+j]) - DIFW'(r_c[j]);
                r_d[AXES+j]   <= DIFW'(r_c[3*AXES+j]) - DIFW'(r_c[2*AXES+j]);
                r_r[j]        <= DIFW'(r_c[j]) - DIFW'(r_c[2*AXES+j]);
            end
        end
    end

    // Dot products.
    logic signed [2*DIFW-1:0] w_paa [AXES];
    logic signed [2*DIFW-1:0] w_pee [AXES];
    logic signed [2*DIFW-1:0] w_pff [AXES];
    logic signed [2*DIFW-1:0] w_pcc [AXES];
    logic signed [2*DIFW-1:0] w_pbb [AXES];

    for (genvar j = 0; j < AXES; j++) begin : g_dot
        spcp_mul #(.AW(DIFW), .BW(DIFW)) u_maa (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_d[j]), .i_b(r_d[j]), .o_p(w_paa[j]));
        spcp_mul #(.AW(DIFW), .BW(DIFW)) u_mee (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_d[AXES+j]), .i_b(r_d[AXES+j]), .o_p(w_pee[j]));
        spcp_mul #(.AW(DIFW), .BW(DIFW)) u_mff (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_d[AXES+j]), .i_b(r_r[j]), .o_p(w_pff[j]));
        spcp_mul #(.AW(DIFW), .BW(DIFW)) u_mcc (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_d[j]), .i_b(r_r[j]), .o_p(w_pcc[j]));
        spcp_mul #(.AW(DIFW), .BW(DIFW)) u_mbb (
            .i_clk(i_clk), .i_en(w_en), .i_a(r_d[j]), .i_b(r_d[AXES+j]), .o_p(w_pbb[j]));
    end

    logic signed [PW-1:0] r_a, r_b, r_cc, r_e, r_f;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a  <= PW'(w_paa[0]) + PW'(w_paa[1]) + PW'(w_paa[2]);
            r_e  <= PW'(w_pee[0]) + PW'(w_pee[1]) + PW'(w_pee[2]);
            r_f  <= PW'(w_pff[0]) + PW'(w_pff[1]) + PW'(w_pff[2]);
            r_cc <= PW'(w_pcc[0]) + PW'(w_pcc[1]) + PW'(w_pcc[2]);
            r_b  <= PW'(w_pbb[0]) + PW'(w_pbb[1]) + PW'(w_pbb[2]);
        end
    end

    // Degeneracy flags and the numerators of the clamped segment one cases.
    logic signed [LW-1:0] w_thr_len;
    logic                 r_deg_a, r_deg_e;
    logic signed [PW:0]   r_negc, r_bmc;
    logic signed [PW-1:0] r_a6;

    assign w_thr_len = $signed(LW'(r_thr)) <<< FB;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_deg_a <= LW'(r_a) <= w_thr_len;
            r_deg_e <= LW'(r_e) <= w_thr_len;
            r_negc  <= -((PW+1)'(r_cc));
            r_bmc   <= (PW+1)'(r_b) - (PW+1)'(r_cc);
            r_a6    <= r_a;
        end
    end

    // Determinant and the general segment one numerator.
    logic signed [2*PW-1:0] w_pae, w_pbb2, w_pbf, w_pce;

    spcp_mul #(.AW(PW), .BW(PW)) u_mae (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_a), .i_b(r_e), .o_p(w_pae));
    spcp_mul #(.AW(PW), .BW(PW)) u_mbb2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b), .i_b(r_b), .o_p(w_pbb2));
    spcp_mul #(.AW(PW), .BW(PW)) u_mbf (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_b), .i_b(r_f), .o_p(w_pbf));
    spcp_mul #(.AW(PW), .BW(PW)) u_mce (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_cc), .i_b(r_e), .o_p(w_pce));

    logic signed [DETW-1:0] r_det, r_nums, r_det9, r_nums9;
    logic signed [TW-1:0]   w_thr_det;
    logic                   r_deg_det;

    assign w_thr_det = $signed(TW'(r_thr)) <<< (3 * FB);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_det     <= DETW'(w_pae) - DETW'(w_pbb2);
            r_nums    <= DETW'(w_pbf) - DETW'(w_pce);
            r_det9    <= r_det;
            r_nums9   <= r_nums;
            r_deg_det <= TW'(r_det) <= w_thr_det;
        end
    end

    logic [FB:0] w_sgen, w_q2, w_q3, w_q4;

    spcp_div #(.NW(DETW), .DW(DETW), .QB(FB)) u_div_s (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_nums9), .i_den(r_det9),
        .i_zero(r_deg_det), .o_q(w_sgen));

    spcp_div #(.NW(PW+1), .DW(PW), .QB(FB)) u_div_c0 (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_negc), .i_den(r_a6),
        .i_zero(1'b0), .o_q(w_q2));

    spcp_div #(.NW(PW+1), .DW(PW), .QB(FB)) u_div_c1 (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_bmc), .i_den(r_a6),
        .i_zero(1'b0), .o_q(w_q3));

    // Segment two parameter from the truncated segment one parameter.
    logic signed [PW-1:0]      w_b_d, w_f_d, w_e_d;
    logic signed [PW+FB+1:0]   w_bs;
    logic signed [NTW-1:0]     r_numt, r_n4;
    logic signed [PW-1:0]      r_f12;
    logic signed [D4W-1:0]     r_d4, w_den_t;
    logic                      w_dega12, r_tneg, r_tgt;

    spcp_dly #(.W(PW), .N(4 + LD)) u_dly_b (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_b), .o_q(w_b_d));
    spcp_dly #(.W(PW), .N(6 + LD)) u_dly_f (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_f), .o_q(w_f_d));
    spcp_dly #(.W(PW), .N(7 + LD)) u_dly_e (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_e), .o_q(w_e_d));
    spcp_dly #(.W(1), .N(6 + LD)) u_dly_dega12 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_deg_a), .o_q(w_dega12));

    spcp_mul #(.AW(PW), .BW(FB+2)) u_mbs (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_b_d), .i_b($signed({1'b0, w_sgen})), .o_p(w_bs));

    assign w_den_t = D4W'(w_e_d) <<< FB;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_numt <= NTW'(w_bs) + (NTW'(w_f_d) <<< FB);
            r_f12  <= w_f_d;
            r_n4   <= w_dega12 ? (NTW'(r_f12) <<< FB) : r_numt;
            r_d4   <= w_den_t;
            r_tneg <= r_numt < 0;
            r_tgt  <= r_numt > NTW'(w_den_t);
        end
    end

    spcp_div #(.NW(NTW), .DW(D4W), .QB(FB)) u_div_t (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_n4), .i_den(r_d4),
        .i_zero(1'b0), .o_q(w_q4));

    // Line everything up at the selection stage.
    logic [FB:0] w_sgen_s, w_q2_s, w_q3_s;
    logic        w_tneg_s, w_tgt_s, w_dega_s, w_dege_s;

    spcp_dly #(.W(FB+1), .N(4 + LD)) u_dly_sgen (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_sgen), .o_q(w_sgen_s));
    spcp_dly #(.W(FB+1), .N(7 + LD)) u_dly_q2 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_q2), .o_q(w_q2_s));
    spcp_dly #(.W(FB+1), .N(7 + LD)) u_dly_q3 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_q3), .o_q(w_q3_s));
    spcp_dly #(.W(2), .N(LD)) u_dly_tflags (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_tneg, r_tgt}), .o_q({w_tneg_s, w_tgt_s}));
    spcp_dly #(.W(2), .N(7 + 2 * LD)) u_dly_deg (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_deg_a, r_deg_e}), .o_q({w_dega_s, w_dege_s}));

    logic [FB:0] r_s, r_t, n_s, n_t;
    logic [FB:0] w_one;

    assign w_one = {1'b1, {FB{1'b0}}};

    always_comb begin
        if (w_dega_s && w_dege_s) begin
            n_s = '0;
            n_t = '0;
        end else if (w_dega_s) begin
            n_s = '0;
            n_t = w_q4;
        end else if (w_dege_s) begin
            n_s = w_q2_s;
            n_t = '0;
        end else if (w_tneg_s) begin
            n_s = w_q2_s;
            n_t = '0;
        end else if (w_tgt_s) begin
            n_s = w_q3_s;
            n_t = w_one;
        end else begin
            n_s = w_sgen_s;
            n_t = w_q4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s <= n_s;
            r_t <= n_t;
        end
    end

    // Start points and directions travel alongside the arithmetic.
    logic [GEOW-1:0] w_geo_in, w_geo;

    for (genvar k = 0; k < 2 * AXES; k++) begin : g_geo
        assign w_geo_in[k*SLW +: SLW] = {r_d[k], r_p[k]};
    end

    spcp_dly #(.W(GEOW), .N(12 + 2 * LD)) u_dly_geo (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_geo_in), .o_q(w_geo));

    logic signed [CW-1:0] w_res [2*AXES];

    for (genvar k = 0; k < 2 * AXES; k++) begin : g_pt
        spcp_point #(.CW(CW), .FB(FB)) u_point (
            .i_clk(i_clk),
            .i_en(w_en),
            .i_p(w_geo[k*SLW +: CW]),
            .i_d(w_geo[k*SLW+CW +: DIFW]),
            .i_s((k < AXES) ? r_s : r_t),
            .o_q(w_res[k])
        );
    end

    always_comb begin
        n_out_data = '0;
        for (int k = 0; k < 2 * AXES; k++) begin
            n_out_data[k*CW +: CW] = w_res[k];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && r_vld[NST-1]) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[NST-1]) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> (r_vld[NST-1] && r_out_valid && !m_axis_tready))
        else $error("pipeline held without back-pressure");

    a_param_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SEL] |-> (r_s <= w_one && r_t <= w_one))
        else $error("segment parameter above one");

    a_both_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[SEL-1] && w_dega_s && w_dege_s) |=> (r_s == '0 && r_t == '0))
        else $error("two point segments gave non-zero parameters");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && m_axis_tready && !r_vld[NST-1]) |=> !r_out_valid)
        else $error("taken word still shown as valid");

endmodule

// ----- sim/segment_pair_closest_points_unit_tb.sv -----
// Self-checking testbench for the segment pair closest points unit.
`timescale 1ns / 1ps

module segment_pair_closest_points_unit_tb;
    import spcp_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int IN_W = IN_FIELDS * CW;
    localparam int OUT_W = OUT_FIELDS * CW;
    localparam int LATENCY = 17 + 2 * (FB + 1);
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [FB:0] ONE_Q = {1'b1, {FB{1'b0}}};

    typedef logic signed [255:0] wide_t;
    typedef logic [CW-1:0] coord_t;
    typedef coord_t pair_t [IN_FIELDS];

    localparam wide_t COORD_MAX = (wide_t'(1) <<< (CW - 1)) - wide_t'(1);
    localparam wide_t COORD_MIN = -(wide_t'(1) <<< (CW - 1));

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [THR_W-1:0] i_cfg_data = '0;

    segment_pair_closest_points_unit #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    logic [THR_W-1:0] threshold;
    logic [IN_W-1:0] pending_pairs[$];
    logic [OUT_W-1:0] expected_points[$];
    int mismatches = 0;
    int cycles = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit hold_sender = 1'b0;

    initial forever #10 i_clk = ~i_clk;

    // Clamped, truncated quotient in Q1.FB; den is positive.
    function automatic logic [FB:0] clamp_div(wide_t num, wide_t den);
        if (num <= 0) return '0;
        if (num >= den) return ONE_Q;
        return (num <<< FB) / den;
    endfunction

    function automatic coord_t place_point(wide_t p, wide_t d, logic [FB:0] s);
        wide_t v;
        v = p + ((d * $signed({1'b0, s}) + (1 << (FB - 1))) >>> FB);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v[CW-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] closest_points(logic [IN_W-1:0] word);
        wide_t s1[3], d1[3], s2[3], d2[3], r[3];
        wide_t a, e, f, c, b, det, num_t, thr_len;
        logic [FB:0] s, t;
        logic [OUT_W-1:0] res;
        for (int i = 0; i < 3; i++) begin
            s1[i] = $signed(word[i*CW +: CW]);
            d1[i] = $signed(word[(3+i)*CW +: CW]) - s1[i];
            s2[i] = $signed(word[(6+i)*CW +: CW]);
            d2[i] = $signed(word[(9+i)*CW +: CW]) - s2[i];
            r[i] = s1[i] - s2[i];
        end
        a = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
        e = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
        f = d2[0]*r[0] + d2[1]*r[1] + d2[2]*r[2];
        c = d1[0]*r[0] + d1[1]*r[1] + d1[2]*r[2];
        b = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
        thr_len = $signed({1'b0, threshold}) <<< FB;
        s = '0;
        t = '0;
        if (a <= thr_len && e <= thr_len) begin
        end else if (a <= thr_len) begin
            t = clamp_div(f, e);
        end else if (e <= thr_len) begin
            s = clamp_div(-c, a);
        end else begin
            det = a * e - b * b;
            if (det > ($signed({1'b0, threshold}) <<< (3 * FB)))
                s = clamp_div(b * f - c * e, det);
            num_t = b * $signed({1'b0, s}) + (f <<< FB);
            if (num_t < 0) begin
                s = clamp_div(-c, a);
            end else if (num_t > (e <<< FB)) begin
                t = ONE_Q;
                s = clamp_div(b - c, a);
            end else begin
                t = clamp_div(num_t, e <<< FB);
            end
        end
        for (int i = 0; i < 3; i++) begin
            res[i*CW +: CW] = place_point(s1[i], d1[i], s);
            res[(3+i)*CW +: CW] = place_point(s2[i], d2[i], t);
        end
        return res;
    endfunction

    task automatic queue_pair(logic [IN_W-1:0] word);
        pending_pairs = {pending_pairs, word};
    endtask

    // Driver: one pair word per handshake; each word draws the gap that follows it.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            expected_points = {expected_points, closest_points(s_axis_tdata)};
        if (!i_rst_n) begin
        end else if (s_axis_tvalid && !s_axis_tready) begin
        end else if (send_wait > 0) begin
            s_axis_tvalid <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (!hold_sender && pending_pairs.size() > 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= pending_pairs.pop_front();
            send_wait <= $urandom_range(0, 3);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: random stalls on the master side, compare against the oldest expectation.
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        int gap;
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected word %h", m_axis_tdata);
            end else begin
                want = expected_points.pop_front();
                for (int k = 0; k < OUT_FIELDS; k++)
                    if (want[k*CW +: CW] !== m_axis_tdata[k*CW +: CW]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Field %0d: expected %h, got %h", k,
                                     want[k*CW +: CW], m_axis_tdata[k*CW +: CW]);
                    end
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            m_axis_tready <= 1'b0;
        end else if (m_axis_tready && m_axis_tvalid) begin
            gap = $urandom_range(0, 3);
            m_axis_tready <= (gap == 0);
            recv_wait <= (gap > 0) ? gap - 1 : 0;
        end else begin
            m_axis_tready <= 1'b1;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("[segment_pair_closest_points_unit] ERROR");
            $finish;
        end
    end

    function automatic coord_t edge_value(int k);
        case (k)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic coord_t near_value(coord_t base, int spread);
        return base + $signed($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Random pair: often a crossing or skew pair at a random scale, sometimes degenerate, nearly
    // degenerate or parallel, sometimes raw noise across the full range or field extremes.
    function automatic logic [IN_W-1:0] random_pair();
        logic [IN_W-1:0] w;
        int kind, spread;
        coord_t centre;
        kind = $urandom_range(0, 9);
        spread = 1 << $urandom_range(2, 24);
        centre = $urandom;
        for (int i = 0; i < IN_FIELDS; i++) w[i*CW +: CW] = near_value(centre, spread);
        case (kind)
            0: for (int i = 0; i < IN_FIELDS; i++) w[i*CW +: CW] = $urandom;
            1: w[3*CW +: 3*CW] = w[0 +: 3*CW];
            2: w[9*CW +: 3*CW] = w[6*CW +: 3*CW];
            3: for (int i = 0; i < 3; i++)
                   w[(3+i)*CW +: CW] = w[i*CW +: CW] + $urandom_range(0, 3);
            4: for (int i = 0; i < 3; i++)
                   w[(9+i)*CW +: CW] = w[(6+i)*CW +: CW]
                                       + w[(3+i)*CW +: CW] - w[i*CW +: CW];
            5: for (int i = 0; i < IN_FIELDS; i++)
                   w[i*CW +: CW] = edge_value($urandom_range(0, 4));
            default: ;
        endcase
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || s_axis_tvalid || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        threshold = value;
    endtask

    initial begin
        logic [IN_W-1:0] w;
        logic [THR_W-1:0] settings [5];
        settings = '{32'd1, 32'd0, 32'hffff_ffff, 32'd65536, 32'd40};
        threshold = THR_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, degenerate points, parallel, clamped ends.
        for (int k = 0; k < 5; k++) begin
            for (int i = 0; i < IN_FIELDS; i++) w[i*CW +: CW] = edge_value((k + i) % 5);
            queue_pair(w);
        end
        w = '0; queue_pair(w);
        w = '0; w[3*CW +: CW] = 32'h0001_0000; queue_pair(w);
        w = '0; w[9*CW +: CW] = 32'h0001_0000; queue_pair(w);
        w = '0; w[3*CW +: CW] = 32'h0002_0000; w[7*CW +: CW] = 32'h0001_0000;
        w[9*CW +: CW] = 32'h0002_0000; w[10*CW +: CW] = 32'h0001_0000;
        queue_pair(w);
        w = '0; w[3*CW +: CW] = 32'h0001_0000; w[6*CW +: CW] = 32'h0003_0000;
        w[7*CW +: CW] = 32'hffff_0000; w[10*CW +: CW] = 32'h0001_0000;
        queue_pair(w);
        w = '0; w[4*CW +: CW] = 32'h0001_0000; w[6*CW +: CW] = 32'hfffe_0000;
        w[8*CW +: CW] = 32'h0001_0000; w[9*CW +: CW] = 32'h0002_0000;
        w[11*CW +: CW] = 32'h0001_0000; queue_pair(w);
        for (int i = 0; i < 10; i++) queue_pair(random_pair());
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            write_threshold(settings[phase]);
            repeat (2) @(posedge i_clk);
            for (int n = 0; n < 380; n++) queue_pair(random_pair());
            if (phase == 2) begin
                while (pending_pairs.size() > 190) @(posedge i_clk);
                hold_sender = 1'b1;
                while (s_axis_tvalid || expected_points.size() > 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("[segment_pair_closest_points_unit] OK");
        else
            $display("[segment_pair_closest_points_unit] ERROR");
        $finish;
    end

endmodule
